// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers clocked on clk with asynchronous reset arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define CWSS_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define CWSS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/cwss_pkg.sv =====
// ----------------------------------------------------------------------------
// cwss_pkg
// shared types, codes and digit helpers of the seven-segment clock
// ----------------------------------------------------------------------------
package cwss_pkg;

	localparam logic [1:0] OP_SCAN   = 2'd0;
	localparam logic [1:0] OP_SECOND = 2'd1;
	localparam logic [1:0] OP_KEY    = 2'd2;

	localparam logic [3:0] KEY_SET   = 4'hF;
	localparam logic [3:0] KEY_MAX   = 4'd9;

	localparam logic [7:0] SEG_DASH  = 8'h40;
	localparam logic [7:0] SEG_BLANK = 8'h00;

	localparam logic [6:0] TIME_RESET = 7'd10;
	localparam logic [6:0] SEC_MAX    = 7'd59;
	localparam logic [6:0] MIN_MAX    = 7'd59;
	localparam logic [6:0] HOUR_MAX   = 7'd23;

	localparam logic [2:0] STEP_NONE = 3'd0;
	localparam logic [2:0] STEP_HT   = 3'd1;
	localparam logic [2:0] STEP_HU   = 3'd2;
	localparam logic [2:0] STEP_MT   = 3'd3;
	localparam logic [2:0] STEP_MU   = 3'd4;
	localparam logic [2:0] STEP_ST   = 3'd5;
	localparam logic [2:0] STEP_SU   = 3'd6;
	localparam logic [2:0] STEP_END  = 3'd7;

	localparam logic [2:0] POS_HT  = 3'd0;
	localparam logic [2:0] POS_HU  = 3'd1;
	localparam logic [2:0] POS_SP1 = 3'd2;
	localparam logic [2:0] POS_MT  = 3'd3;
	localparam logic [2:0] POS_MU  = 3'd4;
	localparam logic [2:0] POS_SP2 = 3'd5;
	localparam logic [2:0] POS_ST  = 3'd6;
	localparam logic [2:0] POS_SU  = 3'd7;

	typedef struct packed {
		logic [6:0] hours;
		logic [6:0] minutes;
		logic [6:0] seconds;
		logic [2:0] scan_pos;
		logic       blink;
		logic       set_mode;
		logic [2:0] entry_step;
	} cwss_state_t;

	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'h3F;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5B;
			4'd3: s = 8'h4F;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6D;
			4'd6: s = 8'h7D;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h6F;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

	// tens digit of a 7-bit value by independent threshold compares
	function automatic logic [3:0] tens_of(input logic [6:0] v);
		logic [3:0] t;
		t = 4'd0;
		for (int i = 1; i <= 12; i++) begin
			if (v >= 7'(i * 10)) begin
				t = 4'(i);
			end
		end
		return t;
	endfunction

	function automatic logic [3:0] units_of(input logic [6:0] v);
		logic [6:0] r;
		r = v - 7'(tens_of(v)) * 7'd10;
		return r[3:0];
	endfunction

endpackage

// ===== hw/rtl/cwss_time.sv =====
// ----------------------------------------------------------------------------
// cwss_time
// time keeping, key entry sequencing and scan position state
// ----------------------------------------------------------------------------
module cwss_time (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [1:0]           operation,
	input  logic [3:0]           key_code,
	output cwss_pkg::cwss_state_t state
);

	cwss_pkg::cwss_state_t state_q;
	cwss_pkg::cwss_state_t nxt;
	logic [6:0] inc_s;
	logic [6:0] inc_m;
	logic [6:0] inc_h;
	logic [6:0] key_tens;
	logic [6:0] key_units;
	logic [2:0] step_inc;

	assign key_tens  = 7'(key_code) * 7'd10;
	assign key_units = 7'(key_code);
	assign step_inc  = state_q.entry_step + 3'd1;

	always_comb begin
		nxt   = state_q;
		inc_s = 7'd0;
		inc_m = 7'd0;
		inc_h = 7'd0;
		case (operation)
			cwss_pkg::OP_SCAN: begin
				nxt.scan_pos = state_q.scan_pos + 3'd1;
			end
			cwss_pkg::OP_SECOND: begin
				nxt.blink = ~state_q.blink;
				if (!state_q.set_mode) begin
					inc_s = state_q.seconds + 7'd1;
					inc_m = state_q.minutes;
					inc_h = state_q.hours;
					if (inc_s > cwss_pkg::SEC_MAX) begin
						inc_s = 7'd0;
						inc_m = state_q.minutes + 7'd1;
					end
					if (inc_m > cwss_pkg::MIN_MAX) begin
						inc_m = 7'd0;
						inc_h = state_q.hours + 7'd1;
					end
					if (inc_h > cwss_pkg::HOUR_MAX) begin
						inc_h = 7'd0;
					end
					nxt.seconds = inc_s;
					nxt.minutes = inc_m;
					nxt.hours   = inc_h;
				end
			end
			cwss_pkg::OP_KEY: begin
				if (key_code == cwss_pkg::KEY_SET) begin
					nxt.set_mode   = 1'b1;
					nxt.entry_step = cwss_pkg::STEP_HT;
				end else if (state_q.set_mode && key_code <= cwss_pkg::KEY_MAX) begin
					case (state_q.entry_step)
						cwss_pkg::STEP_HT: nxt.hours   = key_tens;
						cwss_pkg::STEP_HU: nxt.hours   = state_q.hours + key_units;
						cwss_pkg::STEP_MT: nxt.minutes = key_tens;
						cwss_pkg::STEP_MU: nxt.minutes = state_q.minutes + key_units;
						cwss_pkg::STEP_ST: nxt.seconds = key_tens;
						cwss_pkg::STEP_SU: nxt.seconds = state_q.seconds + key_units;
						default: ;
					endcase
					if (step_inc == cwss_pkg::STEP_END) begin
						nxt.set_mode   = 1'b0;
						nxt.entry_step = cwss_pkg::STEP_NONE;
					end else begin
						nxt.entry_step = step_inc;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.hours      <= cwss_pkg::TIME_RESET;
			state_q.minutes    <= cwss_pkg::TIME_RESET;
			state_q.seconds    <= cwss_pkg::TIME_RESET;
			state_q.scan_pos   <= cwss_pkg::POS_HT;
			state_q.blink      <= 1'b0;
			state_q.set_mode   <= 1'b0;
			state_q.entry_step <= cwss_pkg::STEP_NONE;
		end else if (go) begin
			state_q <= nxt;
		end
	end

	assign state = state_q;

endmodule

// ===== hw/rtl/cwss_seg.sv =====
// ----------------------------------------------------------------------------
// cwss_seg
// segment pattern for the current scan position
// ----------------------------------------------------------------------------
module cwss_seg (
	input  cwss_pkg::cwss_state_t state,
	output logic [7:0]            segments
);

	function automatic logic [7:0] digit(input logic [3:0] d, input logic [2:0] step,
			input cwss_pkg::cwss_state_t st);
		logic [7:0] s;
		if (st.blink && st.entry_step == step) begin
			s = cwss_pkg::SEG_BLANK;
		end else begin
			s = cwss_pkg::seg_of(d);
		end
		return s;
	endfunction

	always_comb begin
		case (state.scan_pos)
			cwss_pkg::POS_HT:
				segments = digit(cwss_pkg::tens_of(state.hours), cwss_pkg::STEP_HT, state);
			cwss_pkg::POS_HU:
				segments = digit(cwss_pkg::units_of(state.hours), cwss_pkg::STEP_HU, state);
			cwss_pkg::POS_MT:
				segments = digit(cwss_pkg::tens_of(state.minutes), cwss_pkg::STEP_MT, state);
			cwss_pkg::POS_MU:
				segments = digit(cwss_pkg::units_of(state.minutes), cwss_pkg::STEP_MU, state);
			cwss_pkg::POS_ST:
				segments = digit(cwss_pkg::tens_of(state.seconds), cwss_pkg::STEP_ST, state);
			cwss_pkg::POS_SU:
				segments = digit(cwss_pkg::units_of(state.seconds), cwss_pkg::STEP_SU, state);
			default:
				segments = state.blink ? cwss_pkg::SEG_DASH : cwss_pkg::SEG_BLANK;
		endcase
	end

endmodule

// ===== hw/rtl/clock_with_seven_segment_scan.sv =====
// ----------------------------------------------------------------------------
// clock_with_seven_segment_scan
// time-of-day clock with key entry and an eight-position display scan
//
// channel  direction  handshake            payload
// in       sink       in_valid / in_stall  operation, key_code
// out      source     out_valid/out_stall  segments, digit_select, *_now, in_set_mode
//
// one request per cycle while no scan request waits: input register, then
// state update and pattern lookup into the output register
// a scan request waits in the input register only while the output holds
// an untaken result; tick and key requests never wait
// reset sets time to 10:10:10, position 0, set mode off
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clock_with_seven_segment_scan (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] operation,
	input  logic [3:0] key_code,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] segments,
	output logic [2:0] digit_select,
	output logic [6:0] hours_now,
	output logic [6:0] minutes_now,
	output logic [6:0] seconds_now,
	output logic       in_set_mode
);

	logic       valid_s1;
	logic [1:0] op_s1;
	logic [3:0] key_s1;
	logic       out_valid_q;
	logic       out_free;
	logic       go;
	logic       is_scan;
	logic [7:0] seg_pat;
	cwss_pkg::cwss_state_t state;

	assign is_scan  = op_s1 == cwss_pkg::OP_SCAN;
	assign out_free = !out_valid_q || !out_stall;
	assign go       = valid_s1 && (!is_scan || out_free);
	assign in_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1  <= operation;
			key_s1 <= key_code;
		end
	end

	cwss_time u_time (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.operation (op_s1),
		.key_code  (key_s1),
		.state     (state)
	);

	cwss_seg u_seg (
		.state    (state),
		.segments (seg_pat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && is_scan) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && is_scan) begin
			segments     <= seg_pat;
			digit_select <= state.scan_pos;
			hours_now    <= state.hours;
			minutes_now  <= state.minutes;
			seconds_now  <= state.seconds;
			in_set_mode  <= state.set_mode;
		end
	end

	assign out_valid = out_valid_q;

	`CWSS_ASSERT_ALWAYS(a_step_in_mode, !state.set_mode || (state.entry_step != cwss_pkg::STEP_NONE && state.entry_step != cwss_pkg::STEP_END))
	`CWSS_ASSERT_ALWAYS(a_step_idle, state.set_mode || state.entry_step == cwss_pkg::STEP_NONE)
	`CWSS_ASSERT_ALWAYS(a_time_range, state.hours <= 7'd99 && state.minutes <= 7'd99 && state.seconds <= 7'd99)
	`CWSS_ASSERT_NEXT(a_scan_adv, go && is_scan, state.scan_pos == $past(state.scan_pos) + 3'd1)

endmodule
